@@ rtl/assert_macros.svh @@
// Assertion macros shared by the stepped auto gain RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define SAGR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define SAGR_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/sagr_pkg.sv @@
// Types, constants and the gain table function for the stepped auto gain block.
package sagr_pkg;

	localparam int SAMPLE_BITS_DEF   = 24;
	localparam int STEP_CENTI_DB_DEF = -100;
	localparam int MAX_STEPS_DEF     = 63;

	localparam int STEP_W     = 6;
	localparam int LEVEL_W    = 23;
	localparam int HOLD_W     = 24;
	localparam int LOG2_W     = 4;
	localparam int GAIN_W     = 20;
	localparam int FRAC_EXT   = 20;
	localparam int ACC_W      = GAIN_W + FRAC_EXT;
	localparam int INC_W      = ACC_W + 1;
	localparam int MAX_LOG2   = 12;
	localparam int RAMP_W     = MAX_LOG2 + 1;
	localparam int TINY_DIFF  = 7;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [LEVEL_W-1:0] REDUCE_RST   = LEVEL_W'(7000000);
	localparam logic [LEVEL_W-1:0] INCREASE_RST = LEVEL_W'(4000000);
	localparam logic [STEP_W-1:0]  MAX_STEPS_RST = STEP_W'(16);
	localparam logic [HOLD_W-1:0]  HOLD_RST     = HOLD_W'(4800);
	localparam logic [LOG2_W-1:0]  BLOCK_LOG2_RST = LOG2_W'(6);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BYPASS,
		CFG_MASTER,
		CFG_REDUCE,
		CFG_INCREASE,
		CFG_MAX_STEPS,
		CFG_HOLD,
		CFG_BLOCK_LOG2
	} cfg_idx_t;

	typedef struct packed {
		logic                     bypass;
		logic                     start;
		logic [STEP_W-1:0]        step;
		logic                     flush;
		logic [GAIN_W-1:0]        g0;
		logic signed [INC_W-1:0]  inc;
		logic [RAMP_W-1:0]        ramp_len;
	} item_ctl_t;

	// Gain of step k in unsigned Q4.16: 10^(centi_db*k/2000), series for the fraction power.
	function automatic logic [GAIN_W-1:0] gain_of(input int k, input int centi_db);
		longint c;
		longint l;
		longint n;
		longint f;
		longint s;
		longint unsigned x;
		longint unsigned term;
		longint unsigned sum;
		longint unsigned gmax;
		gmax = 64'hFFFFF;
		c = longint'(centi_db) * longint'(k);
		l = c * 64'sd891723283 / 64'sd2000;
		n = l >>> 28;
		f = l - (n <<< 28);
		x = ((longint'(f) << 2) * 64'd744261118) >> 30;
		term = 64'd1 << 30;
		sum = term;
		term = (term * x) >> 30;
		sum = sum + term;
		term = ((term * x) >> 30) / 64'd2;
		sum = sum + term;
		term = ((term * x) >> 30) / 64'd3;
		sum = sum + term;
		term = ((term * x) >> 30) / 64'd4;
		sum = sum + term;
		term = ((term * x) >> 30) / 64'd5;
		sum = sum + term;
		term = ((term * x) >> 30) / 64'd6;
		sum = sum + term;
		term = ((term * x) >> 30) / 64'd7;
		sum = sum + term;
		term = ((term * x) >> 30) / 64'd8;
		sum = sum + term;
		term = ((term * x) >> 30) / 64'd9;
		sum = sum + term;
		term = ((term * x) >> 30) / 64'd10;
		sum = sum + term;
		term = ((term * x) >> 30) / 64'd11;
		sum = sum + term;
		term = ((term * x) >> 30) / 64'd12;
		sum = sum + term;
		if (n >= 4) begin
			return GAIN_W'(gmax);
		end
		s = 64'sd14 - n;
		if (s > 40) begin
			return '0;
		end
		sum = (sum + (64'd1 << (s - 1))) >> s;
		if (sum > gmax) begin
			return GAIN_W'(gmax);
		end
		return GAIN_W'(sum);
	endfunction

endpackage

@@ rtl/sagr_if.sv @@
// Channel interfaces: sample input, result output and register write.
interface sagr_in_if
	import sagr_pkg::*;
	#(parameter int SAMPLE_BITS = SAMPLE_BITS_DEF);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;
	logic                          block_start;
	logic [LEVEL_W-1:0]            peak_level;
	logic [STEP_W-1:0]             step_from_master;

	modport source (output valid, sample_in, block_start, peak_level, step_from_master,
		input ready);
	modport sink (input valid, sample_in, block_start, peak_level, step_from_master,
		output ready);
endinterface

interface sagr_out_if
	import sagr_pkg::*;
	#(parameter int SAMPLE_BITS = SAMPLE_BITS_DEF);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic [STEP_W-1:0]             gain_step;
	logic                          flush_peak;

	modport source (output valid, sample_out, gain_step, flush_peak, input ready);
	modport sink (input valid, sample_out, gain_step, flush_peak, output ready);
endinterface

interface sagr_cfg_if
	import sagr_pkg::*;
	;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/sagr_queue.sv @@
// Small first-in first-out queue between the front and back parts.
`include "assert_macros.svh"
module sagr_queue
	import sagr_pkg::*;
	#(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
	) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`SAGR_ASSERT(a_q_no_overflow, push |-> (!full || pop), "queue push while full")
	`SAGR_ASSERT(a_q_no_underflow, pop |-> !empty, "queue pop while empty")
	`SAGR_ASSERT(a_q_count_bound, count_q <= CNT_W'(DEPTH), "queue count past depth")

endmodule

@@ rtl/sagr_front.sv @@
// Front part: registers, step decision, hold count and per-item gain ramp setup.
`include "assert_macros.svh"
module sagr_front
	import sagr_pkg::*;
	#(
	parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
	parameter int STEP_CENTI_DB = STEP_CENTI_DB_DEF,
	parameter int MAX_STEPS     = MAX_STEPS_DEF
	) (
	input  logic                          clk,
	input  logic                          arst_n,
	sagr_in_if.sink                       samples,
	sagr_cfg_if.sink                      cfg,
	input  logic                          q_full,
	output logic                          push,
	output logic signed [SAMPLE_BITS-1:0] push_sample,
	output item_ctl_t                     push_ctl
);
	localparam int TAB_AW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS + 1) : 1;
	localparam int HSUM_W = HOLD_W + 1;
	localparam int SH_W   = 5;
	localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(MAX_STEPS);
	localparam logic signed [GAIN_W:0] TINY_POS = (GAIN_W+1)'(TINY_DIFF);
	localparam logic signed [GAIN_W:0] TINY_NEG = -TINY_POS;

	logic                  bypass_q;
	logic                  master_q;
	logic [LEVEL_W-1:0]    reduce_q;
	logic [LEVEL_W-1:0]    increase_q;
	logic [STEP_W-1:0]     max_steps_q;
	logic [HOLD_W-1:0]     hold_samples_q;
	logic [LOG2_W-1:0]     block_log2_q;

	logic [STEP_W-1:0]     step_q;
	logic [HOLD_W-1:0]     hold_q;

	logic                          valid_s1;
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	logic                          bypass_s1;
	logic                          start_s1;
	logic [STEP_W-1:0]             old_s1;
	logic [STEP_W-1:0]             new_s1;
	logic                          flush_s1;
	logic [LOG2_W-1:0]             lg_s1;

	logic                  accept;
	logic                  advance;
	logic [STEP_W-1:0]     lim;
	logic [STEP_W-1:0]     slave_step;
	logic                  raise;
	logic                  lower;
	logic [STEP_W-1:0]     step_next;
	logic                  flush;
	logic [LOG2_W-1:0]     lg;
	logic [RAMP_W-1:0]     blk_len;
	logic [HOLD_W-1:0]     hold_base;
	logic [HSUM_W-1:0]     hold_sum;
	logic [HOLD_W-1:0]     hold_next;
	logic                  update;

	logic [GAIN_W-1:0]     gain_tab [MAX_STEPS + 1];
	logic [GAIN_W-1:0]     g0;
	logic [GAIN_W-1:0]     g1;
	logic signed [GAIN_W:0] diff;
	logic                  tiny;
	logic [SH_W-1:0]       shamt;
	logic signed [INC_W-1:0] diff_ext;

	for (genvar k = 0; k <= MAX_STEPS; k++) begin : g_tab
		assign gain_tab[k] = gain_of(k, STEP_CENTI_DB);
	end

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bypass_q       <= 1'b0;
			master_q       <= 1'b1;
			reduce_q       <= REDUCE_RST;
			increase_q     <= INCREASE_RST;
			max_steps_q    <= MAX_STEPS_RST;
			hold_samples_q <= HOLD_RST;
			block_log2_q   <= BLOCK_LOG2_RST;
		end else if (cfg.valid) begin
			unique case (cfg_idx_t'(cfg.index))
				CFG_BYPASS:     bypass_q       <= cfg.data[0];
				CFG_MASTER:     master_q       <= cfg.data[0];
				CFG_REDUCE:     reduce_q       <= cfg.data[LEVEL_W-1:0];
				CFG_INCREASE:   increase_q     <= cfg.data[LEVEL_W-1:0];
				CFG_MAX_STEPS:  max_steps_q    <= cfg.data[STEP_W-1:0];
				CFG_HOLD:       hold_samples_q <= cfg.data[HOLD_W-1:0];
				CFG_BLOCK_LOG2: block_log2_q   <= cfg.data[LOG2_W-1:0];
				default: ;
			endcase
		end
	end

	// Step decision on the incoming item.
	always_comb begin
		lim = (max_steps_q < STEP_MAX) ? max_steps_q : STEP_MAX;
		slave_step = (samples.step_from_master > STEP_MAX) ? STEP_MAX
			: samples.step_from_master;
		raise = (samples.peak_level > reduce_q) && (step_q < lim);
		lower = !raise && (samples.peak_level < increase_q) && (step_q != '0)
			&& (hold_q >= hold_samples_q);
		priority if (!master_q) begin
			step_next = slave_step;
		end else if (raise) begin
			step_next = step_q + STEP_W'(1);
		end else if (lower) begin
			step_next = step_q - STEP_W'(1);
		end else begin
			step_next = step_q;
		end
		flush = master_q && (raise || lower);
		lg = (block_log2_q > LOG2_W'(MAX_LOG2)) ? LOG2_W'(MAX_LOG2) : block_log2_q;
		blk_len = RAMP_W'(1) << lg;
		hold_base = flush ? '0 : hold_q;
		hold_sum = {1'b0, hold_base} + HSUM_W'(blk_len);
		hold_next = hold_sum[HOLD_W] ? '1 : hold_sum[HOLD_W-1:0];
	end

	assign advance = valid_s1 && !q_full;
	assign samples.ready = !valid_s1 || !q_full;
	assign accept = samples.valid && samples.ready;
	assign update = accept && !bypass_q && samples.block_start;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= '0;
			hold_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (update) begin
				step_q <= step_next;
				hold_q <= hold_next;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= samples.sample_in;
			bypass_s1 <= bypass_q;
			start_s1  <= samples.block_start && !bypass_q;
			old_s1    <= step_q;
			new_s1    <= update ? step_next : step_q;
			flush_s1  <= update && flush;
			lg_s1     <= lg;
		end
	end

	// Ramp setup: old and new gains, tiny check, per-sample increment.
	always_comb begin
		g0 = gain_tab[old_s1[TAB_AW-1:0]];
		g1 = gain_tab[new_s1[TAB_AW-1:0]];
		diff = $signed({1'b0, g1}) - $signed({1'b0, g0});
		tiny = (diff < TINY_POS) && (diff > TINY_NEG);
		shamt = SH_W'(FRAC_EXT) - SH_W'(lg_s1);
		diff_ext = {{(INC_W - GAIN_W - 1){diff[GAIN_W]}}, diff};
		push_ctl.bypass   = bypass_s1;
		push_ctl.start    = start_s1;
		push_ctl.step     = new_s1;
		push_ctl.flush    = flush_s1;
		push_ctl.g0       = g0;
		push_ctl.inc      = tiny ? '0 : (diff_ext <<< shamt);
		push_ctl.ramp_len = tiny ? '0 : (RAMP_W'(1) << lg_s1);
	end

	assign push = advance;
	assign push_sample = sample_s1;

	`SAGR_ASSERT(a_step_range, step_q <= STEP_MAX, "step index past the table")
	`SAGR_ASSERT(a_flush_moves, (valid_s1 && flush_s1) |-> (start_s1 && (old_s1 != new_s1)),
		"flush without a step change")
	`SAGR_ASSERT(a_bypass_frozen, (accept && bypass_q) |=> (step_q == $past(step_q)),
		"step moved under bypass")

endmodule

@@ rtl/sagr_back.sv @@
// Back part: gain ramp state, sample multiply, rounding, saturation and result register.
`include "assert_macros.svh"
module sagr_back
	import sagr_pkg::*;
	#(
	parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
	parameter int STEP_CENTI_DB = STEP_CENTI_DB_DEF
	) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	input  logic signed [SAMPLE_BITS-1:0] q_sample,
	input  item_ctl_t                     q_ctl,
	output logic                          pop,
	sagr_out_if.source                    results
);
	localparam int PW = SAMPLE_BITS + GAIN_W + 1;
	localparam logic signed [PW-1:0] RND_HALF = PW'(32'sd32768);
	localparam logic signed [PW-1:0] SAT_HI = PW'({1'b0, {(SAMPLE_BITS - 1){1'b1}}});
	localparam logic signed [PW-1:0] SAT_LO = ~SAT_HI;
	localparam logic [ACC_W-1:0] GAIN_RST = {gain_of(0, STEP_CENTI_DB), {FRAC_EXT{1'b0}}};
	localparam logic [RAMP_W-1:0] RAMP_MAX = RAMP_W'(1) << MAX_LOG2;

	logic [ACC_W-1:0]        cur_gain_q;
	logic signed [INC_W-1:0] ramp_inc_q;
	logic [RAMP_W-1:0]       ramp_left_q;

	logic                          valid_s1;
	logic signed [PW-1:0]          product_s1;
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	logic                          bypass_s1;
	logic [STEP_W-1:0]             step_s1;
	logic                          flush_s1;

	logic                          valid_s2;
	logic signed [SAMPLE_BITS-1:0] sample_s2;
	logic [STEP_W-1:0]             step_s2;
	logic                          flush_s2;

	logic                    adv1;
	logic                    adv2;
	logic [GAIN_W-1:0]       gain_used;
	logic [ACC_W-1:0]        base_gain;
	logic signed [INC_W-1:0] base_inc;
	logic [RAMP_W-1:0]       base_left;
	logic [INC_W-1:0]        gain_sum;
	logic signed [PW-1:0]    mul;
	logic signed [PW-1:0]    biased;
	logic signed [PW-1:0]    rnd;
	logic signed [SAMPLE_BITS-1:0] sat;

	assign adv2 = !valid_s2 || results.ready;
	assign adv1 = !valid_s1 || adv2;
	assign pop  = !q_empty && adv1;

	always_comb begin
		gain_used = q_ctl.start ? q_ctl.g0 : cur_gain_q[ACC_W-1:FRAC_EXT];
		base_gain = q_ctl.start ? {q_ctl.g0, {FRAC_EXT{1'b0}}} : cur_gain_q;
		base_inc  = q_ctl.start ? q_ctl.inc : ramp_inc_q;
		base_left = q_ctl.start ? q_ctl.ramp_len : ramp_left_q;
		gain_sum  = {1'b0, base_gain} + base_inc;
		mul = $signed(q_sample) * $signed({1'b0, gain_used});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_gain_q  <= GAIN_RST;
			ramp_inc_q  <= '0;
			ramp_left_q <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
		end else begin
			if (pop && !q_ctl.bypass) begin
				ramp_inc_q <= base_inc;
				if (base_left != '0) begin
					cur_gain_q  <= gain_sum[ACC_W-1:0];
					ramp_left_q <= base_left - RAMP_W'(1);
				end else begin
					cur_gain_q  <= base_gain;
					ramp_left_q <= '0;
				end
			end
			if (adv1) begin
				valid_s1 <= pop;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			product_s1 <= mul;
			sample_s1  <= q_sample;
			bypass_s1  <= q_ctl.bypass;
			step_s1    <= q_ctl.step;
			flush_s1   <= q_ctl.flush && !q_ctl.bypass;
		end
	end

	// Round to nearest with ties upward, then clamp.
	always_comb begin
		biased = product_s1 + RND_HALF;
		rnd = biased >>> 16;
		priority if (rnd > SAT_HI) begin
			sat = SAT_HI[SAMPLE_BITS-1:0];
		end else if (rnd < SAT_LO) begin
			sat = SAT_LO[SAMPLE_BITS-1:0];
		end else begin
			sat = rnd[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && valid_s1) begin
			sample_s2 <= bypass_s1 ? sample_s1 : sat;
			step_s2   <= step_s1;
			flush_s2  <= flush_s1;
		end
	end

	assign results.valid      = valid_s2;
	assign results.sample_out = sample_s2;
	assign results.gain_step  = step_s2;
	assign results.flush_peak = flush_s2;

	`SAGR_ASSERT(a_ramp_bound, ramp_left_q < RAMP_MAX, "ramp count past block length")
	`SAGR_ASSERT(a_pop_fills, pop |=> valid_s1, "popped item not held in multiply stage")

endmodule

@@ rtl/stepped_auto_gain_with_ramp.sv @@
// Top level of the stepped automatic gain control with per-block gain ramp.
// One sample is taken and one result given per clock cycle at full rate when nothing stalls:
// the front registers the step decision in one stage, a four-entry queue decouples it from the
// back, which multiplies in one stage and rounds and saturates into the result register. The
// rate is set by the step index and hold count, which are updated at each block start outside
// bypass, and by the one multiplier in the back stage.
module stepped_auto_gain_with_ramp
	import sagr_pkg::*;
	#(
	parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
	parameter int STEP_CENTI_DB = STEP_CENTI_DB_DEF,
	parameter int MAX_STEPS     = MAX_STEPS_DEF
	) (
	input  logic       clk,
	input  logic       arst_n,
	sagr_in_if.sink    samples,
	sagr_cfg_if.sink   cfg,
	sagr_out_if.source results
);
	localparam int CTL_W = $bits(item_ctl_t);
	localparam int ITEM_W = SAMPLE_BITS + CTL_W;

	logic                          push;
	logic                          pop;
	logic                          q_full;
	logic                          q_empty;
	logic signed [SAMPLE_BITS-1:0] push_sample;
	item_ctl_t                     push_ctl;
	logic [ITEM_W-1:0]             q_rdata;
	logic signed [SAMPLE_BITS-1:0] q_sample;
	item_ctl_t                     q_ctl;

	sagr_front #(
		.SAMPLE_BITS   (SAMPLE_BITS),
		.STEP_CENTI_DB (STEP_CENTI_DB),
		.MAX_STEPS     (MAX_STEPS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.samples     (samples),
		.cfg         (cfg),
		.q_full      (q_full),
		.push        (push),
		.push_sample (push_sample),
		.push_ctl    (push_ctl)
	);

	sagr_queue #(
		.WIDTH (ITEM_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  ({push_sample, push_ctl}),
		.pop    (pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	assign q_sample = q_rdata[ITEM_W-1:CTL_W];
	assign q_ctl    = item_ctl_t'(q_rdata[CTL_W-1:0]);

	sagr_back #(
		.SAMPLE_BITS   (SAMPLE_BITS),
		.STEP_CENTI_DB (STEP_CENTI_DB)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_sample (q_sample),
		.q_ctl    (q_ctl),
		.pop      (pop),
		.results  (results)
	);

endmodule
